### src/lgm_pkg.sv
// Shared types, constants and helper functions for the luma gradient map block.
// Used by lgm_color_table and luma_gradient_map_screen_blend_top; no dependencies.
package lgm_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int CHANNEL_BITS  = 8;
    localparam int RGB_BITS      = 48;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Luma weights in Q16, summing to 65536.
    localparam logic [15:0] W_RED   = 16'd19589;
    localparam logic [15:0] W_GREEN = 16'd38444;
    localparam logic [15:0] W_BLUE  = 16'd7503;

    // 65536 * 255, the inverted-luma numerator for a black pixel.
    localparam logic [23:0] LUMA_FULL = 24'd16711680;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [39:0] CAP_Q31 = 40'h80_0000_0000;
    localparam logic [47:0] HALF_Q31 = 48'h0000_4000_0000;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_USE_LIGHT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_THRES = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_GAIN  = 2'd2;

    typedef struct packed {
        logic       last;
        logic [7:0] src_r;
        logic [7:0] src_g;
        logic [7:0] src_b;
        logic [7:0] src_a;
        logic [7:0] lt_r;
        logic [7:0] lt_g;
        logic [7:0] lt_b;
        logic [7:0] lt_a;
    } t_pix;

    // First estimate of y / 255 from the series y/256 + y/256^2 + ...
    // It is never above the true quotient and at most five below it.
    function automatic logic [32:0] div255_est(input logic [39:0] y);
        return 33'(y >> 8) + 33'(y >> 16) + 33'(y >> 24) + 33'(y >> 32);
    endfunction

    // Correction to add to the estimate: the remainder is below 2048, where
    // (r + 1 + r/256) / 256 is an exact division by 255.
    function automatic logic [2:0] div255_fix(input logic [39:0] y,
                                              input logic [32:0] q);
        logic [40:0] rem_w;
        logic [10:0] rem;
        logic [11:0] s;
        rem_w = {1'b0, y} - ({q, 8'b0} - {8'b0, q});
        rem   = rem_w[10:0];
        s     = {1'b0, rem} + 12'd1 + 12'(rem >> 8);
        return s[10:8];
    endfunction

endpackage

### src/lgm_color_table.sv
// Color table: two copies of the 48-bit gradient table so that two neighboring
// entries can be read in the same cycle. Depends on lgm_pkg.
module lgm_color_table (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [lgm_pkg::IDX_BITS-1:0]  i_waddr,
    input  logic [lgm_pkg::RGB_BITS-1:0]  i_wdata,
    input  logic                          i_rd_en,
    input  logic [lgm_pkg::IDX_BITS-1:0]  i_raddr_a,
    input  logic [lgm_pkg::IDX_BITS-1:0]  i_raddr_b,
    output logic [lgm_pkg::RGB_BITS-1:0]  o_rdata_a,
    output logic [lgm_pkg::RGB_BITS-1:0]  o_rdata_b
);
    import lgm_pkg::*;

    logic [RGB_BITS-1:0] r_mem_a [TABLE_ENTRIES];
    logic [RGB_BITS-1:0] r_mem_b [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_a[i_waddr] <= i_wdata;
            r_mem_b[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            o_rdata_a <= r_mem_a[i_raddr_a];
            o_rdata_b <= r_mem_b[i_raddr_b];
        end
    end

endmodule

### src/luma_gradient_map_screen_blend_top.sv
// Top level of the luma gradient map with light screen blend.
// Depends on lgm_pkg and lgm_color_table.
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready  | command, table load fields, pixel fields
//  output   | o_out_valid / i_out_ready| out_r/g/b/a, out_last
//  config   | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One word is accepted every cycle unless the output is stalled.
// The pipeline depth is set by the table read and the two divisions by 255.
// A load word writes the table at its accept edge and gives no result.
// A stalled output holds the whole pipeline and drops o_in_ready.
// Reset is synchronous; it clears the valid bits and sets the config registers to their defaults.
module luma_gradient_map_screen_blend_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [7:0]                         i_table_index,
    input  logic [47:0]                        i_table_rgb,
    input  logic [7:0]                         i_src_r,
    input  logic [7:0]                         i_src_g,
    input  logic [7:0]                         i_src_b,
    input  logic [7:0]                         i_src_a,
    input  logic [7:0]                         i_light_r,
    input  logic [7:0]                         i_light_g,
    input  logic [7:0]                         i_light_b,
    input  logic [7:0]                         i_light_a,
    input  logic                               i_frame_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_out_r,
    output logic [7:0]                         o_out_g,
    output logic [7:0]                         o_out_b,
    output logic [7:0]                         o_out_a,
    output logic                               o_out_last,
    input  logic                               i_cfg_we,
    input  logic [lgm_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [lgm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import lgm_pkg::*;

    logic               adv;
    logic               in_acc;
    logic               r_use_light;
    logic signed [15:0] r_thres;
    logic [15:0]        r_gain;

    logic [9:1] r_vld;
    t_pix       r_pix [9:1];

    // Stage 1: address generation.
    logic [23:0]         luma_sum;
    logic [23:0]         inv_luma;
    logic [IDX_BITS-1:0] addr_a;
    logic [IDX_BITS-1:0] addr_b;
    logic [RGB_BITS-1:0] rd_a;
    logic [RGB_BITS-1:0] rd_b;
    logic signed [25:0]  thres_ext;
    logic signed [25:0]  la_ext;
    logic signed [25:0]  d_val;

    // Stage 2.
    logic [15:0]        r_frac2;
    logic signed [25:0] r_d2;
    logic [31:0]        spec [3];
    logic [39:0]        dg;

    // Stage 3.
    logic [31:0] r_spec3 [3];
    logic [39:0] r_dg3;
    logic        neg [3];
    logic [31:0] om [3];
    logic [39:0] yt [3];
    logic [7:0]  lt3 [3];

    // Stage 4.
    logic [31:0] r_spec4 [3];
    logic        r_neg4 [3];
    logic [39:0] r_yt4 [3];
    logic [35:0] r_hy4;
    logic [32:0] r_qh4;
    logic [32:0] qt [3];

    // Stage 5.
    logic [31:0] r_spec5 [3];
    logic        r_neg5 [3];
    logic [39:0] r_yt5 [3];
    logic [32:0] r_qt5 [3];
    logic [27:0] r_h5;

    // Stage 6.
    logic [31:0] r_spec6 [3];
    logic        r_neg6 [3];
    logic [31:0] r_t6 [3];
    logic [27:0] r_h6;
    logic [45:0] plo [3];

    // Stage 7.
    logic [31:0] r_spec7 [3];
    logic        r_neg7 [3];
    logic [31:0] r_t7 [3];
    logic [13:0] r_hhi7;
    logic [45:0] r_plo7 [3];
    logic [59:0] tot [3];

    // Stage 8.
    logic [31:0] r_spec8 [3];
    logic        r_neg8 [3];
    logic [42:0] r_m8 [3];
    logic [43:0] add_w [3];
    logic [39:0] res [3];

    // Stage 9.
    logic [39:0] r_v9 [3];
    logic [7:0]  r_a9;
    logic [47:0] prod [3];
    logic [7:0]  chan_out [3];
    logic [7:0]  n_out_r;
    logic [7:0]  n_out_g;
    logic [7:0]  n_out_b;
    logic [7:0]  n_out_a;

    logic        r_out_valid;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign in_acc     = i_in_valid && adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_light <= 1'b0;
            r_thres     <= 16'sd4096;
            r_gain      <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_USE_LIGHT:   r_use_light <= i_cfg_data[0];
                REG_LIGHT_THRES: r_thres     <= $signed(i_cfg_data);
                REG_LIGHT_GAIN:  r_gain      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[8:1], in_acc && (i_command == CMD_PIXEL)};
            r_out_valid <= r_vld[9];
        end
    end

    // Stage 1 comb: inverted luma. TABLE_ENTRIES-1 equals the channel maximum,
    // so the table position in Q16 is the inverted luma itself.
    always_comb begin
        luma_sum = 24'(W_RED * r_pix[1].src_r) + 24'(W_GREEN * r_pix[1].src_g)
                 + 24'(W_BLUE * r_pix[1].src_b);
        inv_luma = (luma_sum >= LUMA_FULL) ? 24'd0 : LUMA_FULL - luma_sum;
        addr_a   = inv_luma[23:16];
        addr_b   = (addr_a == IDX_BITS'(TABLE_ENTRIES - 1)) ? addr_a : addr_a + 1'b1;
        thres_ext = {{10{r_thres[15]}}, r_thres};
        la_ext    = $signed({6'b0, r_pix[1].lt_a, 12'b0});
        d_val     = la_ext - thres_ext * 26'sd255;
    end

    lgm_color_table u_table (
        .i_clk     (i_clk),
        .i_we      (in_acc && (i_command == CMD_LOAD)),
        .i_waddr   (i_table_index),
        .i_wdata   (i_table_rgb),
        .i_rd_en   (adv),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Stage 2 comb: linear blend of the two entries, and the light factor product.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            spec[c] = 32'(rd_a[47-16*c -: 16] * (17'h10000 - {1'b0, r_frac2})
                        + rd_b[47-16*c -: 16] * {1'b0, r_frac2});
        end
        dg = (r_d2 > 26'sd0) ? 40'(r_d2[23:0] * r_gain) : 40'd0;
    end

    // Stage 3 comb: distance from one, times the light channel.
    always_comb begin
        lt3[0] = r_pix[3].lt_r;
        lt3[1] = r_pix[3].lt_g;
        lt3[2] = r_pix[3].lt_b;
        for (int c = 0; c < 3; c++) begin
            neg[c] = r_spec3[c] > ONE_Q31;
            om[c]  = neg[c] ? r_spec3[c] - ONE_Q31 : ONE_Q31 - r_spec3[c];
            yt[c]  = 40'(om[c] * lt3[c]);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            qt[c]  = div255_est(r_yt4[c]);
            plo[c] = 46'(r_t6[c] * r_h6[13:0]);
            tot[c] = {46'(r_t7[c] * r_hhi7), 14'b0} + {14'b0, r_plo7[c]};
        end
    end

    // Stage 8 comb: apply the screen term and clamp.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            add_w[c] = {12'b0, r_spec8[c]} + {1'b0, r_m8[c]};
            if (r_neg8[c]) begin
                res[c] = ({11'b0, r_m8[c]} >= {22'b0, r_spec8[c]}) ? 40'd0
                       : {8'b0, r_spec8[c] - r_m8[c][31:0]};
            end else begin
                res[c] = (add_w[c] > {4'b0, CAP_Q31}) ? CAP_Q31 : add_w[c][39:0];
            end
        end
    end

    // Stage 9 comb: scale by alpha, round and saturate, then the bypass cases.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c]     = 48'(r_v9[c] * r_a9) + HALF_Q31;
            chan_out[c] = (prod[c][47:31] > 17'd255) ? 8'hFF : prod[c][38:31];
        end
        n_out_r = chan_out[0];
        n_out_g = chan_out[1];
        n_out_b = chan_out[2];
        n_out_a = r_a9;
        if (!r_use_light && r_pix[9].src_a == 8'd0) begin
            n_out_r = r_pix[9].src_r;
            n_out_g = r_pix[9].src_g;
            n_out_b = r_pix[9].src_b;
            n_out_a = r_pix[9].src_a;
        end else if (r_use_light && r_pix[9].lt_a == 8'd0) begin
            n_out_r = 8'd0;
            n_out_g = 8'd0;
            n_out_b = 8'd0;
            n_out_a = 8'd0;
        end
    end

    // Datapath registers, all held while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pix[1] <= '{last: i_frame_last, src_r: i_src_r, src_g: i_src_g,
                          src_b: i_src_b, src_a: i_src_a, lt_r: i_light_r,
                          lt_g: i_light_g, lt_b: i_light_b, lt_a: i_light_a};
            for (int k = 2; k <= 9; k++) begin
                r_pix[k] <= r_pix[k-1];
            end

            r_frac2 <= inv_luma[15:0];
            r_d2    <= d_val;

            r_dg3 <= dg;

            r_hy4 <= r_dg3[39:4];
            r_qh4 <= div255_est({4'b0, r_dg3[39:4]});

            r_h5 <= 28'(r_qh4 + 33'(div255_fix({4'b0, r_hy4}, r_qh4)));

            r_h6 <= r_h5;

            r_hhi7 <= r_h6[27:14];

            for (int c = 0; c < 3; c++) begin
                r_spec3[c] <= spec[c];

                r_spec4[c] <= r_spec3[c];
                r_neg4[c]  <= neg[c];
                r_yt4[c]   <= yt[c];

                r_spec5[c] <= r_spec4[c];
                r_neg5[c]  <= r_neg4[c];
                r_yt5[c]   <= r_yt4[c];
                r_qt5[c]   <= qt[c];

                r_spec6[c] <= r_spec5[c];
                r_neg6[c]  <= r_neg5[c];
                r_t6[c]    <= 32'(r_qt5[c] + 33'(div255_fix(r_yt5[c], r_qt5[c])));

                r_spec7[c] <= r_spec6[c];
                r_neg7[c]  <= r_neg6[c];
                r_t7[c]    <= r_t6[c];
                r_plo7[c]  <= plo[c];

                r_spec8[c] <= r_spec7[c];
                r_neg8[c]  <= r_neg7[c];
                r_m8[c]    <= tot[c][58:16];

                r_v9[c] <= r_use_light ? res[c] : {8'b0, r_spec8[c]};
            end
            r_a9 <= r_use_light ? r_pix[8].lt_a : r_pix[8].src_a;

            o_out_r    <= n_out_r;
            o_out_g    <= n_out_g;
            o_out_b    <= n_out_b;
            o_out_a    <= n_out_a;
            o_out_last <= r_pix[9].last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
